FILE: rtl/core/height_field_wave_step_macros.svh
// assertion macros for the height field wave step block
// no dependencies; included by files that carry concurrent assertions
`ifndef HEIGHT_FIELD_WAVE_STEP_MACROS_SVH
`define HEIGHT_FIELD_WAVE_STEP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, sampled on clk_i, off during reset
`define HFWS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, sampled on clk_i, off during reset
`define HFWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define HFWS_ASSERT_IMPL(label, ante, cons)
`define HFWS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/core/hfws_pkg.sv
// shared types, constants and saturation helper for the height field wave step block
// no dependencies
package hfws_pkg;

  localparam int unsigned DefMaxPoints = 4096;
  localparam int unsigned DefMaxWidth  = 64;

  // 4.94974747 in q16.16 and 0.001 in q0.32
  localparam logic [22:0] DiagK = 23'd324387;
  localparam logic [22:0] VelK  = 23'd4294967;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_STEP  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_NOP   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    REG_GRID_WIDTH = 2'd0,
    REG_GRID_ROWS  = 2'd1,
    REG_DIFF_LIMIT = 2'd2,
    REG_HEIGHT_CAP = 2'd3
  } reg_idx_e;

  // saturate a wide signed value to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [39:0] v);
    logic [31:0] r;
    if (v > 40'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -40'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/height_field_wave_step.sv
// height field wave step: height, velocity and force stores with a sequenced step engine
// depends on hfws_pkg and height_field_wave_step_macros.svh
//
//  channel   handshake                 payload
//  -------   -----------------------   -------------------------------------------
//  command   start && !busy            kind, point_index, height_value
//  result    result_valid_o (strobe)   read_height_o, step_done_o
//  config    cfg_we_i                  cfg_index_i, cfg_wdata_i
//
// a no-op item passes through ST_FIN, a write through ST_WR and ST_FIN, and a read through
// ST_RD0, ST_RD1 and ST_FIN; the result strobe comes as busy drops. a step first shrinks the
// rows until the grid fits the stores; its pace is set by the single read port of each store:
// every neighbor is one read, multiply, write turn.
// after reset a clearing pass zeroes the velocity store; busy is high meanwhile and config
// writes are still taken. the result strobe lasts one cycle and cannot be stalled, so the
// block never waits on the receiver.
`include "height_field_wave_step_macros.svh"

module height_field_wave_step #(
  parameter int unsigned MAX_POINTS = hfws_pkg::DefMaxPoints,
  parameter int unsigned MAX_WIDTH  = hfws_pkg::DefMaxWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [11:0] point_index_i,
  input  logic [31:0] height_value_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  output logic        result_valid_o,
  output logic [31:0] read_height_o,
  output logic        step_done_o
);
  import hfws_pkg::*;

  localparam int unsigned AW = $clog2(MAX_POINTS);
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_VCLR, ST_WR, ST_RD0, ST_RD1, ST_GEOM, ST_FCLR, ST_DLIM0, ST_DLIM1,
    ST_CRD, ST_CCAP, ST_NRD, ST_NCAP, ST_NMUL, ST_NUPD, ST_CWR, ST_URD, ST_UMUL,
    ST_UWR, ST_FIN
  } state_e;

  typedef enum logic [2:0] {
    NB_LEFT, NB_UP, NB_RIGHT, NB_DOWN, NB_DOWN_RIGHT, NB_UP_LEFT, NB_DOWN_LEFT, NB_UP_RIGHT
  } nbr_e;

  // configuration registers
  logic [6:0]  grid_width_q, grid_rows_q;
  logic [30:0] diff_limit_q;
  logic [31:0] height_cap_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q <= 7'd64;
      grid_rows_q  <= 7'd64;
      diff_limit_q <= 31'd2621;
      height_cap_q <= 32'h7FFF_FFFF;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_GRID_WIDTH: grid_width_q <= cfg_wdata_i[6:0];
        REG_GRID_ROWS:  grid_rows_q  <= cfg_wdata_i[6:0];
        REG_DIFF_LIMIT: diff_limit_q <= cfg_wdata_i[30:0];
        REG_HEIGHT_CAP: height_cap_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // control and datapath registers
  state_e        st_q;
  nbr_e          nbr_q;
  logic [AW-1:0] pt_q, addr_q;
  logic [CW-1:0] cnt_q;
  logic [6:0]    w_q, r_q, row_q, col_q;
  logic          in_range_q, is_step_q;
  logic [31:0]   wdata_q, res_h_q, hc_q, fc_q;
  logic [32:0]   diff_q;         // two's complement
  logic [55:0]   product_q;
  logic          sign_q;
  logic [35:0]   dlim_q;
  logic          valid_q, step_done_q;
  logic [31:0]   read_height_q;

  // store read data
  logic [31:0] h_rd_q, v_rd_q, f_rd_q;

  assign busy           = (st_q != ST_IDLE);
  assign result_valid_o = valid_q;
  assign read_height_o  = read_height_q;
  assign step_done_o    = step_done_q;

  // neighbor address of the current interior point
  logic [AW-1:0] w_a, nb_addr;
  assign w_a = AW'(w_q);
  always_comb begin
    unique case (nbr_q)
      NB_LEFT:       nb_addr = pt_q - AW'(1);
      NB_UP:         nb_addr = pt_q - w_a;
      NB_RIGHT:      nb_addr = pt_q + AW'(1);
      NB_DOWN:       nb_addr = pt_q + w_a;
      NB_DOWN_RIGHT: nb_addr = pt_q + w_a + AW'(1);
      NB_UP_LEFT:    nb_addr = pt_q - w_a - AW'(1);
      NB_DOWN_LEFT:  nb_addr = pt_q + w_a - AW'(1);
      NB_UP_RIGHT:   nb_addr = pt_q - w_a + AW'(1);
      default:       nb_addr = pt_q;
    endcase
  end

  logic is_diag;
  assign is_diag = (nbr_q == NB_DOWN_RIGHT) || (nbr_q == NB_UP_LEFT) ||
                   (nbr_q == NB_DOWN_LEFT) || (nbr_q == NB_UP_RIGHT);

  // shared multiplier: magnitude times constant, rounded at bit 16 or 32
  logic [32:0] mul_mag;
  logic [22:0] mul_k;
  logic        mul_sign;
  always_comb begin
    mul_mag  = diff_q[32] ? (~diff_q + 33'd1) : diff_q;
    mul_k    = DiagK;
    mul_sign = diff_q[32];
    if (st_q == ST_DLIM0) begin
      mul_mag  = {2'b00, diff_limit_q};
      mul_sign = 1'b0;
    end else if (st_q == ST_UMUL) begin
      mul_mag  = f_rd_q[31] ? (~{1'b1, f_rd_q} + 33'd1) : {1'b0, f_rd_q};
      mul_k    = VelK;
      mul_sign = f_rd_q[31];
    end
  end

  logic [56:0] sum16, sum32;
  logic [35:0] rnd16;
  logic [23:0] rnd32;
  assign sum16 = {1'b0, product_q} + 57'h8000;
  assign sum32 = {1'b0, product_q} + 57'h8000_0000;
  assign rnd16 = sum16[51:16];
  assign rnd32 = sum32[55:32];

  // exchange term: clamped edge difference or scaled and clamped diagonal difference
  logic signed [36:0] d_raw, d_lim, d_sel;
  always_comb begin
    if (is_diag) begin
      d_raw = sign_q ? -$signed({1'b0, rnd16}) : $signed({1'b0, rnd16});
      d_lim = $signed({1'b0, dlim_q});
    end else begin
      d_raw = 37'($signed(diff_q));
      d_lim = $signed({6'd0, diff_limit_q});
    end
    if (d_raw > d_lim) begin
      d_sel = d_lim;
    end else if (d_raw < -d_lim) begin
      d_sel = -d_lim;
    end else begin
      d_sel = d_raw;
    end
  end

  logic [31:0] f_nb_new, f_c_new;
  assign f_nb_new = sat32(40'($signed(f_rd_q)) + 40'(d_sel));
  assign f_c_new  = sat32(40'($signed(fc_q)) - 40'(d_sel));

  // velocity and height update
  logic signed [24:0] gain;
  logic [31:0]        v_new, h_sum, h_new;
  assign gain  = sign_q ? -$signed({1'b0, rnd32}) : $signed({1'b0, rnd32});
  assign v_new = sat32(40'($signed(v_rd_q)) + 40'(gain));
  assign h_sum = sat32(40'($signed(h_rd_q)) + 40'($signed(v_new)));
  assign h_new = ($signed(h_sum) > $signed(height_cap_q)) ? height_cap_q : h_sum;

  // store ports
  logic [AW-1:0] rd_addr, h_wa, f_wa;
  logic          h_we, v_we, f_we;
  logic [31:0]   h_wd, v_wd, f_wd;
  always_comb begin
    rd_addr = pt_q;
    h_wa    = pt_q;
    f_wa    = pt_q;
    h_we    = 1'b0;
    v_we    = 1'b0;
    f_we    = 1'b0;
    h_wd    = h_new;
    v_wd    = v_new;
    f_wd    = '0;
    unique case (st_q)
      ST_RD0, ST_RD1: rd_addr = addr_q;
      ST_WR: begin
        h_wa = addr_q;
        h_we = in_range_q;
        h_wd = wdata_q;
      end
      ST_VCLR: begin
        v_we = 1'b1;
        v_wd = '0;
      end
      ST_FCLR: f_we = 1'b1;
      ST_NRD, ST_NCAP, ST_NMUL: rd_addr = nb_addr;
      ST_NUPD: begin
        rd_addr = nb_addr;
        f_wa    = nb_addr;
        f_we    = 1'b1;
        f_wd    = f_nb_new;
      end
      ST_CWR: begin
        f_we = 1'b1;
        f_wd = fc_q;
      end
      ST_UWR: begin
        h_we = 1'b1;
        v_we = 1'b1;
      end
      default: ;
    endcase
  end

  logic [31:0] h_mem [MAX_POINTS];
  logic [31:0] v_mem [MAX_POINTS];
  logic [31:0] f_mem [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (h_we) begin
      h_mem[h_wa] <= h_wd;
    end
    h_rd_q <= h_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      v_mem[pt_q] <= v_wd;
    end
    v_rd_q <= v_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (f_we) begin
      f_mem[f_wa] <= f_wd;
    end
    f_rd_q <= f_mem[rd_addr];
  end

  // geometry helpers
  logic [13:0] area;
  logic [6:0]  w_eff, r_min;
  assign area  = 14'(w_q) * 14'(r_q);
  assign w_eff = (32'(grid_width_q) < 32'd3) ? 7'd3 :
                 (32'(grid_width_q) > MAX_WIDTH) ? 7'(MAX_WIDTH) : grid_width_q;
  assign r_min = (grid_rows_q < 7'd3) ? 7'd3 : grid_rows_q;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q          <= ST_VCLR;
      nbr_q         <= NB_LEFT;
      pt_q          <= '0;
      addr_q        <= '0;
      cnt_q         <= '0;
      w_q           <= 7'd3;
      r_q           <= 7'd3;
      row_q         <= 7'd1;
      col_q         <= 7'd1;
      in_range_q    <= 1'b0;
      is_step_q     <= 1'b0;
      valid_q       <= 1'b0;
      step_done_q   <= 1'b0;
      read_height_q <= '0;
      res_h_q       <= '0;
    end else begin
      valid_q       <= 1'b0;
      step_done_q   <= 1'b0;
      read_height_q <= '0;
      unique case (st_q)
        ST_IDLE: begin
          if (start) begin
            addr_q     <= AW'(point_index_i);
            in_range_q <= (32'(point_index_i) < MAX_POINTS);
            wdata_q    <= height_value_i;
            res_h_q    <= '0;
            is_step_q  <= 1'b0;
            unique case (kind_e'(kind_i))
              KIND_WRITE: st_q <= ST_WR;
              KIND_READ:  st_q <= ST_RD0;
              KIND_STEP: begin
                is_step_q <= 1'b1;
                w_q       <= w_eff;
                r_q       <= r_min;
                st_q      <= ST_GEOM;
              end
              default: st_q <= ST_FIN;
            endcase
          end
        end
        ST_VCLR: begin
          pt_q <= pt_q + AW'(1);
          if (pt_q == AW'(MAX_POINTS - 1)) begin
            st_q <= ST_IDLE;
          end
        end
        ST_WR: st_q <= ST_FIN;
        ST_RD0: st_q <= ST_RD1;
        ST_RD1: begin
          res_h_q <= in_range_q ? h_rd_q : '0;
          st_q    <= ST_FIN;
        end
        // shrink rows until the grid fits the stores
        ST_GEOM: begin
          if (32'(area) > MAX_POINTS) begin
            r_q <= r_q - 7'd1;
          end else begin
            cnt_q <= CW'(area);
            pt_q  <= '0;
            st_q  <= (area == '0) ? ST_FIN : ST_FCLR;
          end
        end
        ST_FCLR: begin
          pt_q <= pt_q + AW'(1);
          if (CW'(pt_q) == cnt_q - CW'(1)) begin
            st_q <= ST_DLIM0;
          end
        end
        ST_DLIM0: begin
          product_q <= mul_mag * mul_k;
          sign_q    <= mul_sign;
          st_q      <= ST_DLIM1;
        end
        ST_DLIM1: begin
          dlim_q <= rnd16;
          nbr_q  <= NB_LEFT;
          row_q  <= 7'd1;
          col_q  <= 7'd1;
          if (r_q < 7'd3) begin
            pt_q <= '0;
            st_q <= ST_URD;
          end else begin
            pt_q <= w_a + AW'(1);
            st_q <= ST_CRD;
          end
        end
        ST_CRD: st_q <= ST_CCAP;
        ST_CCAP: begin
          hc_q <= h_rd_q;
          fc_q <= f_rd_q;
          st_q <= ST_NRD;
        end
        ST_NRD: st_q <= ST_NCAP;
        ST_NCAP: begin
          diff_q <= {hc_q[31], hc_q} - {h_rd_q[31], h_rd_q};
          st_q   <= ST_NMUL;
        end
        ST_NMUL: begin
          product_q <= mul_mag * mul_k;
          sign_q    <= mul_sign;
          st_q      <= ST_NUPD;
        end
        ST_NUPD: begin
          fc_q  <= f_c_new;
          nbr_q <= nbr_e'(nbr_q + 3'd1);
          st_q  <= (nbr_q == NB_UP_RIGHT) ? ST_CWR : ST_NRD;
        end
        // write back the center force and move to the next interior point, or to the update pass after the last
        ST_CWR: begin
          nbr_q <= NB_LEFT;
          if (col_q == w_q - 7'd2) begin
            if (row_q == r_q - 7'd2) begin
              pt_q <= '0;
              st_q <= ST_URD;
            end else begin
              row_q <= row_q + 7'd1;
              col_q <= 7'd1;
              pt_q  <= pt_q + AW'(3);
              st_q  <= ST_CRD;
            end
          end else begin
            col_q <= col_q + 7'd1;
            pt_q  <= pt_q + AW'(1);
            st_q  <= ST_CRD;
          end
        end
        ST_URD: st_q <= ST_UMUL;
        ST_UMUL: begin
          product_q <= mul_mag * mul_k;
          sign_q    <= mul_sign;
          st_q      <= ST_UWR;
        end
        ST_UWR: begin
          pt_q <= pt_q + AW'(1);
          st_q <= (CW'(pt_q) == cnt_q - CW'(1)) ? ST_FIN : ST_URD;
        end
        // result transfer
        ST_FIN: begin
          valid_q       <= 1'b1;
          step_done_q   <= is_step_q;
          read_height_q <= res_h_q;
          st_q          <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // an accepted command always makes the block busy
  `HFWS_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // the result transfer comes as the block returns to idle
  `HFWS_ASSERT_IMPL(a_result_idle, result_valid_o, !busy)
  // a neighbor force write never lands on the cached center entry
  `HFWS_ASSERT_IMPL(a_nb_not_center, f_we && (st_q == ST_NUPD), nb_addr != pt_q)
  // a step result carries a zero height
  `HFWS_ASSERT_IMPL(a_step_zero, step_done_o, result_valid_o && (read_height_o == '0))

endmodule
